// File: hdl/drl_pkg.sv
// ----------------------------------------------------------------------------
// drl_pkg: shared types and constants of the decaying rate limiter
// Microcode format, step names, control/status bundles and fixed-point sizes.
// ----------------------------------------------------------------------------
package drl_pkg;

  localparam int TIME_W          = 32;
  localparam int SIZE_W          = 32;
  localparam int LIMIT_W         = 20;
  localparam int COUNT_INT_BITS  = 34;
  localparam int THR_W           = 34;
  localparam int Q_W             = 32;
  localparam int APB_DW          = 32;
  localparam int APB_AW          = 3;

  localparam int DEF_FRACTION_BITS = 16;
  localparam int DEF_ELAPSED_BITS  = 16;
  localparam int DEF_DECAY_WINDOW  = 600;

  localparam logic [THR_W-1:0] THR_SCALE = THR_W'(10000);
  localparam logic [Q_W:0]     Q_ONE     = {1'b1, {Q_W{1'b0}}};
  localparam logic [Q_W-1:0]   Q_HALF    = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic REG_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_POW,
    OP_LO,
    OP_HI,
    OP_SUM,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_WAIT_IN,
    C_LOOP,
    C_WAIT_OUT
  } cond_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_LOAD = 3'd0;
  localparam step_t S_POW  = 3'd1;
  localparam step_t S_LO   = 3'd2;
  localparam step_t S_HI   = 3'd3;
  localparam step_t S_SUM  = 3'd4;
  localparam step_t S_EMIT = 3'd5;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic loop_last;
  } drl_status_t;

  typedef struct packed {
    op_t  op;
    logic act;
  } drl_ctrl_t;

  function automatic uword_t drl_ucode(input step_t step);
    uword_t w;
    case (step)
      S_LOAD:  w = '{op: OP_LOAD, cond: C_WAIT_IN,  target: S_LOAD};
      S_POW:   w = '{op: OP_POW,  cond: C_LOOP,     target: S_POW};
      S_LO:    w = '{op: OP_LO,   cond: C_NEXT,     target: S_HI};
      S_HI:    w = '{op: OP_HI,   cond: C_NEXT,     target: S_SUM};
      S_SUM:   w = '{op: OP_SUM,  cond: C_NEXT,     target: S_EMIT};
      S_EMIT:  w = '{op: OP_EMIT, cond: C_WAIT_OUT, target: S_LOAD};
      default: w = '{op: OP_NOP,  cond: C_NEXT,     target: S_LOAD};
    endcase
    return w;
  endfunction

  // Square a 0.32 power k times with rounding; elaboration only.
  function automatic logic [Q_W-1:0] pow_q32(input logic [Q_W-1:0] p0, input int k);
    logic [63:0] p;
    p = 64'(p0);
    for (int i = 0; i < k; i++) begin
      p = (p * p + 64'(Q_HALF)) >> Q_W;
    end
    return p[Q_W-1:0];
  endfunction

endpackage

// File: hdl/drl_seq.sv
// ----------------------------------------------------------------------------
// drl_seq: microcode sequencer
// Step counter over a read-only control store with wait, loop and jump tests.
// ----------------------------------------------------------------------------
module drl_seq
  import drl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  drl_status_t status,
  output drl_ctrl_t   ctrl
);

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   go;

  assign uw = drl_ucode(step_r);

  always_comb begin
    go       = 1'b1;
    step_nxt = STEP_W'(step_r + STEP_W'(1));
    case (uw.cond)
      C_NEXT: begin
        go = 1'b1;
      end
      C_WAIT_IN: begin
        go = status.in_valid;
        if (!go) begin
          step_nxt = step_r;
        end
      end
      C_LOOP: begin
        if (!status.loop_last) begin
          step_nxt = uw.target;
        end
      end
      C_WAIT_OUT: begin
        go = !status.out_busy;
        step_nxt = go ? uw.target : step_r;
      end
      default: begin
        go = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl.op  = uw.op;
  assign ctrl.act = go;

endmodule

// File: hdl/decaying_rate_limiter.sv
// ----------------------------------------------------------------------------
// decaying_rate_limiter: exponentially decaying flow counter with threshold
// Decays a running count by the elapsed seconds, then refuses or counts a beat.
// ----------------------------------------------------------------------------
// Input beat: in_now_seconds and in_item_size on in_valid/in_ready. Result
// beat: out_exceeded on out_valid/out_ready, one per input beat, in order.
// APB port (psel..pready): the flow limit at byte address 0; pready is tied
// high, prdata returns the limit. Write it only while the block is idle.
// One item at a time: in_ready is high only on the load step. The decay
// factor is built by one shared 33x33 multiplier, one elapsed-time bit per
// cycle, followed by the two halves of the count product and a final add.
// An input beat is taken on the load step; the power, low, high, sum and emit
// steps follow, and the emit step loads the result register. The next input
// beat is taken on the load step that follows the emit step.
// A finished result waits in the output register; the next input beat is
// accepted meanwhile, and the block holds before loading a second result
// until the first is taken.
// Reset clears the count, the stored time, the limit and the output.
// ----------------------------------------------------------------------------
module decaying_rate_limiter
  import drl_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int ELAPSED_BITS  = DEF_ELAPSED_BITS,
  parameter int DECAY_WINDOW  = DEF_DECAY_WINDOW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TIME_W-1:0] in_now_seconds,
  input  logic [SIZE_W-1:0] in_item_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_exceeded,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int COUNT_W = COUNT_INT_BITS + FRACTION_BITS;
  localparam int K_W     = $clog2(ELAPSED_BITS);
  localparam int MUL_W   = 2 * (Q_W + 1);
  localparam logic [Q_W-1:0] P0 = Q_W'(
    (((64'(DECAY_WINDOW) - 64'd1) << Q_W) + 64'(DECAY_WINDOW) / 64'd2) / 64'(DECAY_WINDOW));

  drl_status_t status;
  drl_ctrl_t   ctrl;

  logic [LIMIT_W-1:0]      limit_r;
  logic [THR_W-1:0]        thr_r;
  logic [TIME_W-1:0]       last_r;
  logic [SIZE_W-1:0]       size_r;
  logic [ELAPSED_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [K_W-1:0]          k_r;
  logic [Q_W:0]            acc_r;
  logic [Q_W:0]            lo_r;
  logic [COUNT_W-1:0]      hi_prod_r;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic                    out_valid_r;
  logic                    out_exceeded_r;

  logic [Q_W-1:0]          pow_tab [ELAPSED_BITS];
  logic [Q_W:0]            mul_a, mul_b;
  logic [MUL_W-1:0]        mul_p, mul_rnd;
  logic [TIME_W:0]         diff;
  logic [COUNT_W:0]        sum_wide, add_wide;
  logic                    exceed;
  logic                    cfg_wr;

  for (genvar g = 0; g < ELAPSED_BITS; g++) begin : g_pow
    assign pow_tab[g] = pow_q32(P0, g);
  end

  drl_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign status.in_valid  = in_valid;
  assign status.out_busy  = out_valid_r && !out_ready;
  assign status.loop_last = (k_r == K_W'(ELAPSED_BITS - 1));

  assign in_ready = (ctrl.op == OP_LOAD);

  // shared multiplier
  always_comb begin
    mul_a = acc_r;
    case (ctrl.op)
      OP_POW:  mul_b = {1'b0, pow_tab[k_r]};
      OP_LO:   mul_b = {1'b0, count_r[Q_W-1:0]};
      OP_HI:   mul_b = (Q_W + 1)'(count_r[COUNT_W-1:Q_W]);
      default: mul_b = '0;
    endcase
  end

  assign mul_p   = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign mul_rnd = mul_p + MUL_W'(Q_HALF);

  // elapsed seconds: backwards time is zero, long gaps saturate
  assign diff = {1'b0, in_now_seconds} - {1'b0, last_r};
  always_comb begin
    if (diff[TIME_W] || diff == '0) begin
      elapsed_nxt = '0;
    end else if (diff[TIME_W-1:ELAPSED_BITS] != '0) begin
      elapsed_nxt = '1;
    end else begin
      elapsed_nxt = diff[ELAPSED_BITS-1:0];
    end
  end

  assign sum_wide = (COUNT_W + 1)'(hi_prod_r) + (COUNT_W + 1)'(lo_r);
  assign add_wide = (COUNT_W + 1)'(count_r) +
                    (COUNT_W + 1)'({size_r, {FRACTION_BITS{1'b0}}});
  assign exceed   = (count_r >= {thr_r, {FRACTION_BITS{1'b0}}});

  always_comb begin
    count_nxt = count_r;
    if (ctrl.act && ctrl.op == OP_SUM) begin
      count_nxt = sum_wide[COUNT_W-1:0];
    end else if (ctrl.act && ctrl.op == OP_EMIT && !exceed) begin
      count_nxt = add_wide[COUNT_W] ? '1 : add_wide[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act) begin
      case (ctrl.op)
        OP_LOAD: begin
          size_r    <= in_item_size;
          elapsed_r <= elapsed_nxt;
          acc_r     <= Q_ONE;
          k_r       <= '0;
        end
        OP_POW: begin
          if (elapsed_r[k_r]) begin
            acc_r <= mul_rnd[2*Q_W:Q_W];
          end
          k_r <= K_W'(k_r + K_W'(1));
        end
        OP_LO: begin
          lo_r <= mul_rnd[2*Q_W:Q_W];
        end
        OP_HI: begin
          hi_prod_r <= mul_p[COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r        <= '0;
      thr_r          <= '0;
      last_r         <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      out_exceeded_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_LIMIT) begin
        limit_r <= pwdata[LIMIT_W-1:0];
        thr_r   <= THR_W'(THR_W'(pwdata[LIMIT_W-1:0]) * THR_SCALE);
      end
      if (ctrl.act && ctrl.op == OP_LOAD) begin
        last_r <= in_now_seconds;
      end
      count_r <= count_nxt;
      if (ctrl.act && ctrl.op == OP_EMIT) begin
        out_valid_r    <= 1'b1;
        out_exceeded_r <= exceed;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_exceeded = out_exceeded_r;
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_LIMIT) ? APB_DW'(limit_r) : '0;

`ifndef SYNTHESIS
  a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.act && ctrl.op == OP_EMIT))
    else $error("result beat raised outside the emit step");

  a_decay_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.act && ctrl.op == OP_SUM) |=> (count_r <= $past(count_r)))
    else $error("decay step increased the count");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_POW || ctrl.op == OP_LO || ctrl.op == OP_HI) |-> (acc_r <= Q_ONE))
    else $error("decay factor above one");
`endif

endmodule

// File: tb/drl_checker.sv
// ----------------------------------------------------------------------------
// drl_checker: verdict predictor and scoreboard for the decaying rate limiter
// Watches the APB port, the input channel and the result channel at the rising
// edge. Tracks the decayed flow count, the last timestamp and the flow limit,
// predicts the exceeded bit of every input beat and compares each result beat
// with the oldest prediction. Also checks limit readback on APB reads.
// ----------------------------------------------------------------------------
module drl_checker
  import drl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [TIME_W-1:0] in_now_seconds,
  input  logic [SIZE_W-1:0] in_item_size,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_exceeded,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  localparam int COUNT_W = COUNT_INT_BITS + DEF_FRACTION_BITS;
  localparam logic [63:0] COUNT_MAX   = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [63:0] ELAPSED_MAX = (64'd1 << DEF_ELAPSED_BITS) - 64'd1;
  localparam logic [63:0] LOW_WORD    = 64'hFFFF_FFFF;
  localparam logic [APB_AW-1:0] LIMIT_ADDR = APB_AW'(4 * int'(REG_LIMIT));

  logic [COUNT_W-1:0] flow_count;
  logic [TIME_W-1:0]  last_stamp;
  logic [LIMIT_W-1:0] flow_limit;
  logic               verdict_q[$];

  // Decay factor over secs seconds in 0.32 format, 2^32 standing for 1.0.
  function automatic logic [63:0] decay_factor_q32(input logic [DEF_ELAPSED_BITS-1:0] secs);
    logic [63:0] pw;
    logic [63:0] acc;
    pw  = (((64'(DEF_DECAY_WINDOW) - 64'd1) << Q_W) + 64'(DEF_DECAY_WINDOW) / 64'd2)
          / 64'(DEF_DECAY_WINDOW);
    acc = 64'(Q_ONE);
    for (int k = 0; k < DEF_ELAPSED_BITS; k++) begin
      if (secs[k]) acc = (acc * pw + 64'(Q_HALF)) >> Q_W;
      pw = (pw * pw + 64'(Q_HALF)) >> Q_W;
    end
    return acc;
  endfunction

  // Decay the count, record the timestamp, then refuse or count the beat.
  function automatic logic judge_item(input logic [TIME_W-1:0] stamp,
                                      input logic [SIZE_W-1:0] amount);
    logic [63:0] secs;
    logic [63:0] factor;
    logic [63:0] cnt;
    logic [63:0] thr;
    secs = (stamp > last_stamp) ? 64'(stamp - last_stamp) : 64'd0;
    if (secs > ELAPSED_MAX) secs = ELAPSED_MAX;
    factor = decay_factor_q32(secs[DEF_ELAPSED_BITS-1:0]);
    cnt = (64'(flow_count) >> Q_W) * factor
        + (((64'(flow_count) & LOW_WORD) * factor + 64'(Q_HALF)) >> Q_W);
    last_stamp = stamp;
    thr = (64'(flow_limit) * 64'(THR_SCALE)) << DEF_FRACTION_BITS;
    if (cnt >= thr) begin
      flow_count = cnt[COUNT_W-1:0];
      return 1'b1;
    end
    cnt = cnt + (64'(amount) << DEF_FRACTION_BITS);
    if (cnt > COUNT_MAX) cnt = COUNT_MAX;
    flow_count = cnt[COUNT_W-1:0];
    return 1'b0;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    flow_count = '0;
    last_stamp = '0;
    flow_limit = '0;
  end

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      flow_count = '0;
      last_stamp = '0;
      flow_limit = '0;
      verdict_q.delete();
    end else begin
      if (psel && penable && pready && pwrite && paddr == LIMIT_ADDR)
        flow_limit = pwdata[LIMIT_W-1:0];
      if (psel && penable && pready && !pwrite && paddr == LIMIT_ADDR &&
          prdata !== APB_DW'(flow_limit)) begin
        $display("%0t: limit readback mismatch, expected %0h, actual %0h",
                 $time, APB_DW'(flow_limit), prdata);
        fail_count++;
      end
      if (in_valid && in_ready)
        verdict_q.push_back(judge_item(in_now_seconds, in_item_size));
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with nothing pending, expected none, actual %0b",
                   $time, out_exceeded);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_exceeded !== want) begin
            $display("%0t: exceeded mismatch, expected %0b, actual %0b",
                     $time, want, out_exceeded);
            fail_count++;
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the decaying rate limiter
// Drives directed beats covering the zero limit, the threshold boundary,
// backward and saturating time jumps and large sizes, then random phases over
// several flow limits with random sender gaps and receiver stalls. A separate
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top
  import drl_pkg::*;
();

  localparam logic [APB_AW-1:0] LIMIT_ADDR = APB_AW'(4 * int'(REG_LIMIT));
  localparam logic [APB_AW-1:0] SPARE_ADDR = LIMIT_ADDR + APB_AW'(4);
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;
  localparam int PHASES = 10;
  localparam int PHASE_BEATS = 123;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [TIME_W-1:0] in_now_seconds = '0;
  logic [SIZE_W-1:0] in_item_size = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_exceeded;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  bit                quiet = 1'b0;
  logic [TIME_W-1:0] stamp;
  logic [LIMIT_W-1:0] phase_limit[PHASES];

  always #2 clk = ~clk;

  decaying_rate_limiter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_now_seconds(in_now_seconds), .in_item_size(in_item_size),
    .out_valid(out_valid), .out_ready(out_ready), .out_exceeded(out_exceeded),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  drl_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_now_seconds(in_now_seconds), .in_item_size(in_item_size),
    .out_valid(out_valid), .out_ready(out_ready), .out_exceeded(out_exceeded),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // Hold out_ready low for a drawn number of valid cycles after each beat.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) hold = quiet ? 0 : $urandom_range(0, 12);
      else if (out_valid && hold > 0) hold--;
      @(negedge clk);
      out_ready <= (hold == 0);
    end
  end

  task automatic send_item(input logic [TIME_W-1:0] t, input logic [SIZE_W-1:0] sz);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_now_seconds <= t;
    in_item_size   <= sz;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic cfg_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] lim);
    drain_results();
    cfg_access(1'b1, LIMIT_ADDR, APB_DW'(lim));
    cfg_access(1'b0, LIMIT_ADDR, '0);
  endtask

  function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      return t + TIME_W'($urandom_range(0, 3));
    else if (r < 82) return t + TIME_W'($urandom_range(4, 3000));
    else if (r < 88) return t + TIME_W'($urandom_range(65536, 200000));
    else if (r < 94) return t - TIME_W'($urandom_range(1, 1000));
    else if (r < 97) return TIME_W'($urandom);
    return t;
  endfunction

  function automatic logic [SIZE_W-1:0] next_size(input logic [LIMIT_W-1:0] lim);
    int r;
    logic [63:0] big;
    r = $urandom_range(0, 99);
    if (r < 8)  return SIZE_W'($urandom);
    if (r < 12) return '0;
    if (r < 15) return '1;
    big = (64'(lim) * 64'(THR_SCALE) / 64'd400) * 64'($urandom_range(0, 300)) / 64'd100;
    return (big > 64'hFFFF_FFFF) ? '1 : big[SIZE_W-1:0];
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero limit after reset: every beat refused
    send_item(32'd0, 32'd0);
    send_item(32'd5, 32'hFFFF_FFFF);

    set_limit(LIMIT_W'(1));
    send_item(32'd10, 32'hFFFF_FFFF);
    send_item(32'd10, 32'd1);
    send_item(32'd3, 32'd0);
    send_item(32'h0001_0100, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd9999);
    send_item(32'hFFFF_FFFF, 32'd1);
    send_item(32'hFFFF_FFFF, 32'd0);
    send_item(32'd0, 32'd5);
    send_item(32'd1, 32'd0);
    send_item(32'h5555_5555, 32'hAAAA_AAAA);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);

    set_limit(LIMIT_TOP);
    send_item(32'h0001_0000, 32'hFFFF_FFFF);
    send_item(32'h0001_0000, 32'hFFFF_FFFF);
    send_item(32'h0001_0000, 32'hFFFF_FFFF);
    send_item(32'h0001_0000, 32'h8000_0000);
    send_item(32'h0001_0001, 32'd1);

    // write to an unmapped address must leave the limit alone
    drain_results();
    cfg_access(1'b1, SPARE_ADDR, '1);
    cfg_access(1'b0, LIMIT_ADDR, '0);
    send_item(32'h0001_0001, 32'd7);
    send_item(32'h0002_0000, 32'd7);

    phase_limit = '{LIMIT_W'(1), LIMIT_W'(7), LIMIT_W'(250), '0, LIMIT_TOP,
                    LIMIT_W'(0), LIMIT_W'(1000), '0, LIMIT_W'(30), LIMIT_TOP};
    phase_limit[3] = LIMIT_W'($urandom_range(1, (1 << LIMIT_W) - 1));
    phase_limit[7] = LIMIT_W'($urandom_range(1, (1 << LIMIT_W) - 1));
    stamp = 32'h0002_0000;

    for (int ph = 0; ph < PHASES; ph++) begin
      set_limit(phase_limit[ph]);
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 2 && n == 60) drain_results();
        stamp = next_stamp(stamp);
        send_item(stamp, next_size(phase_limit[ph]));
      end
    end

    drain_results();
    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("decaying_rate_limiter test passed");
    else $display("decaying_rate_limiter test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("decaying_rate_limiter test failed");
    $finish;
  end

endmodule
